/* src/priority_dma_transfer_queue_defines.svh */
// ----------------------------------------------------------------------------
// priority_dma_transfer_queue_defines
// Assertion macros for the priority DMA transfer queue.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_DMA_TRANSFER_QUEUE_DEFINES_SVH
`define PRIORITY_DMA_TRANSFER_QUEUE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define PDQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked on every rising clock edge outside reset.
`define PDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/pdq_pkg.sv */
// ----------------------------------------------------------------------------
// pdq_pkg
// Shared constants and types for the priority DMA transfer queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pdq_pkg;
  localparam int SLOT_COUNT = 10;
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [7:0] TIMEOUT_RESET = 8'd15;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_TICK    = 2'd1,
    OP_DONE    = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] current_time;
    logic [23:0] dest_address;
    logic [18:0] source_address;
    logic [13:0] length_bytes;
    logic [7:0]  priority_req;
    logic        preload_flag;
    logic [31:0] query_handle;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] issued_handle;
    logic        transfer_finished;
    logic        start_valid;
    logic [23:0] start_memory_address;
    logic [15:0] start_sound_address;
    logic [7:0]  start_block_count;
    logic        preload_begin;
    logic        preload_end;
    logic        engine_busy;
    logic [3:0]  queued_count;
  } out_beat_t;

  // One slot entry as held in the slot memory.
  typedef struct packed {
    logic [31:0] handle;
    logic [23:0] mem_addr;
    logic [15:0] snd_addr;
    logic [7:0]  blocks;
    logic [7:0]  prio;
    logic        preload;
    logic [31:0] deadline;
  } slot_t;
endpackage
`default_nettype wire

/* src/pdq_stream_if.sv */
// ----------------------------------------------------------------------------
// pdq_in_if / pdq_out_if
// Valid-ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface pdq_in_if;
  logic valid;
  logic ready;
  pdq_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pdq_out_if;
  logic valid;
  logic ready;
  pdq_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/priority_dma_transfer_queue.sv */
// ----------------------------------------------------------------------------
// priority_dma_transfer_queue
// Ten-slot prioritized DMA request queue with deadlines and completion query.
// ----------------------------------------------------------------------------
// Each input beat is one operation: enqueue, service tick, DMA done or
// completion query, and produces exactly one result beat. All slot state
// lives in a single slot memory with a registered synchronous read; a
// sequencer walks the slots one per cycle. The longest item is an enqueue
// into the last free slot that also retires an expired transfer and starts
// the next one, which needs a free-slot walk and a priority walk; a query
// doing the same needs a priority walk and a handle walk. The slot walks
// over the single memory port set how long an item takes. A new item is
// taken only when the previous result has left the output register. The
// timeout register may be written only while idle. After reset the block
// sweeps the slot memory, one slot per cycle, clearing handles before it
// accepts its first beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "priority_dma_transfer_queue_defines.svh"
module priority_dma_transfer_queue (
  input  wire logic       clk,
  input  wire logic       rst_n,
  pdq_in_if.sink          in_ch,
  pdq_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);
  localparam int SW = pdq_pkg::SLOT_W;
  localparam int CW = pdq_pkg::CNT_W;
  localparam logic [SW-1:0] LAST = SW'(pdq_pkg::SLOT_COUNT - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FREE_SCAN, S_SERVICE, S_DL_WAIT, S_RETIRE,
    S_BEST_SCAN, S_START, S_QUERY_SCAN, S_OUTPUT
  } state_t;

  // Slot memory: one write port, one registered read port.
  pdq_pkg::slot_t mem [pdq_pkg::SLOT_COUNT];
  pdq_pkg::slot_t rd_q;
  logic [SW-1:0]  rd_addr;
  logic           wr_en;
  logic [SW-1:0]  wr_addr;
  pdq_pkg::slot_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  state_t             state_r, state_nxt;
  pdq_pkg::in_beat_t  req_r, req_nxt;
  pdq_pkg::out_beat_t res_r, res_nxt;
  logic [7:0]  timeout_r;
  logic [31:0] hcnt_r, hcnt_nxt;
  logic [CW-1:0] pend_r, pend_nxt;
  logic [SW-1:0] active_r, active_nxt;
  logic busy_r, busy_nxt, pon_r, pon_nxt;
  logic [SW-1:0] idx_r, idx_nxt;     // address issued this cycle
  logic          rvld_r, rvld_nxt;   // rd_q holds valid read data; in the walks and on retire, of slot rd_idx_r
  logic [SW-1:0] rd_idx_r, rd_idx_nxt;
  logic          found_r, found_nxt;
  logic [SW-1:0] best_r, best_nxt;
  logic [7:0]    bprio_r, bprio_nxt;
  logic [31:0]   bhandle_r, bhandle_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [14:0]   len_up;

  assign in_ch.ready   = (state_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid  = ovalid_r;
  assign out_ch.data   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= pdq_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // Round up to whole 64-byte blocks; the count keeps eight bits.
  assign len_up = {1'b0, req_r.length_bytes} + ((req_r.length_bytes[5:0] != 6'd0) ?
                  15'h40 : 15'h0);

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    res_nxt     = res_r;
    hcnt_nxt    = hcnt_r;
    pend_nxt    = pend_r;
    active_nxt  = active_r;
    busy_nxt    = busy_r;
    pon_nxt     = pon_r;
    idx_nxt     = idx_r;
    rvld_nxt    = 1'b0;
    rd_idx_nxt  = idx_r;
    found_nxt   = found_r;
    best_nxt    = best_r;
    bprio_nxt   = bprio_r;
    bhandle_nxt = bhandle_r;
    ovalid_nxt  = ovalid_r;
    rd_addr     = idx_r;
    wr_en       = 1'b0;
    wr_addr     = idx_r;
    wr_data     = rd_q;

    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
        idx_nxt = idx_r + SW'(1);
        if (idx_r == LAST) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid && !ovalid_r) begin
          req_nxt  = in_ch.data;
          res_nxt  = '0;
          idx_nxt  = '0;
          rvld_nxt = 1'b0;
          unique case (pdq_pkg::op_t'(in_ch.data.operation))
            pdq_pkg::OP_ENQUEUE: begin
              hcnt_nxt  = (hcnt_r == 32'hFFFF_FFFF) ? 32'd1 : hcnt_r + 32'd1;
              state_nxt = S_FREE_SCAN;
            end
            pdq_pkg::OP_DONE: state_nxt = S_RETIRE;
            default: state_nxt = S_SERVICE;
          endcase
        end
      end
      S_FREE_SCAN: begin
        // Issue reads one per cycle; check the slot returned last cycle.
        rd_addr    = idx_r;
        rvld_nxt   = 1'b1;
        rd_idx_nxt = idx_r;
        idx_nxt    = (idx_r == LAST) ? idx_r : idx_r + SW'(1);
        if (rvld_r && rd_q.handle == 32'd0) begin
          wr_en            = 1'b1;
          wr_addr          = rd_idx_r;
          wr_data.handle   = hcnt_r;
          wr_data.mem_addr = req_r.dest_address;
          wr_data.snd_addr = req_r.source_address[18:3];
          wr_data.blocks   = len_up[13:6];
          wr_data.prio     = req_r.priority_req;
          wr_data.preload  = req_r.preload_flag;
          wr_data.deadline = rd_q.deadline;
          pend_nxt         = pend_r + CW'(1);
          res_nxt.issued_handle = hcnt_r;
          rvld_nxt  = 1'b0;
          state_nxt = S_SERVICE;
        end else if (rvld_r && rd_idx_r == LAST) begin
          rvld_nxt  = 1'b0;
          state_nxt = S_OUTPUT;
        end
      end
      S_SERVICE: begin
        if (!busy_r) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = (pend_r == '0) ? S_QUERY_SCAN : S_BEST_SCAN;
          if (pend_r == '0) begin
            rd_addr = '0;
          end
        end else begin
          rd_addr   = active_r;
          state_nxt = S_DL_WAIT;
        end
      end
      S_DL_WAIT: begin
        if (rd_q.deadline <= req_r.current_time) begin
          state_nxt = S_RETIRE;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_QUERY_SCAN;
        end
      end
      S_RETIRE: begin
        // Read the active slot, then clear it on the following cycle if it holds a handle.
        rd_addr = active_r;
        if (!rvld_r) begin
          rvld_nxt   = 1'b1;
          rd_idx_nxt = active_r;
        end else begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          if (rd_q.handle != 32'd0) begin
            wr_en          = 1'b1;
            wr_addr        = active_r;
            wr_data.handle = 32'd0;
            if (pon_r) begin
              pon_nxt             = 1'b0;
              res_nxt.preload_end = 1'b1;
            end
            if (pend_r > CW'(1)) begin
              pend_nxt  = pend_r - CW'(1);
              state_nxt = S_BEST_SCAN;
            end else begin
              pend_nxt  = '0;
              busy_nxt  = 1'b0;
              state_nxt = S_QUERY_SCAN;
            end
          end else begin
            state_nxt = (pend_r == '0) ? S_QUERY_SCAN : S_BEST_SCAN;
          end
        end
      end
      S_BEST_SCAN: begin
        rd_addr    = idx_r;
        rvld_nxt   = (idx_r != LAST) || !rvld_r || (rd_idx_r != LAST);
        rd_idx_nxt = idx_r;
        idx_nxt    = (idx_r == LAST) ? idx_r : idx_r + SW'(1);
        if (rvld_r && rd_q.handle != 32'd0 &&
            (!found_r || rd_q.prio > bprio_r ||
             (rd_q.prio == bprio_r && rd_q.handle < bhandle_r))) begin
          found_nxt   = 1'b1;
          best_nxt    = rd_idx_r;
          bprio_nxt   = rd_q.prio;
          bhandle_nxt = rd_q.handle;
        end
        if (rvld_r && rd_idx_r == LAST) begin
          rvld_nxt  = 1'b0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        rd_addr = best_r;
        if (!found_r) begin
          idx_nxt   = '0;
          state_nxt = S_QUERY_SCAN;
        end else if (!rvld_r) begin
          rvld_nxt = 1'b1;
        end else begin
          wr_en            = 1'b1;
          wr_addr          = best_r;
          wr_data.deadline = req_r.current_time + {24'd0, timeout_r};
          busy_nxt         = 1'b1;
          active_nxt       = best_r;
          if (rd_q.preload) begin
            pon_nxt               = 1'b1;
            res_nxt.preload_begin = 1'b1;
          end
          res_nxt.start_valid          = 1'b1;
          res_nxt.start_memory_address = rd_q.mem_addr;
          res_nxt.start_sound_address  = rd_q.snd_addr;
          res_nxt.start_block_count    = rd_q.blocks;
          idx_nxt   = '0;
          state_nxt = S_QUERY_SCAN;
        end
      end
      S_QUERY_SCAN: begin
        if (pdq_pkg::op_t'(req_r.operation) != pdq_pkg::OP_QUERY) begin
          state_nxt = S_OUTPUT;
        end else begin
          res_nxt.transfer_finished = (rvld_r) ? res_r.transfer_finished : 1'b1;
          rd_addr    = idx_r;
          rvld_nxt   = 1'b1;
          rd_idx_nxt = idx_r;
          idx_nxt    = (idx_r == LAST) ? idx_r : idx_r + SW'(1);
          if (req_r.query_handle == 32'd0 || pend_r == '0) begin
            rvld_nxt  = 1'b0;
            state_nxt = S_OUTPUT;
          end else if (rvld_r) begin
            if (rd_q.handle == req_r.query_handle) begin
              res_nxt.transfer_finished = 1'b0;
            end
            if (rd_idx_r == LAST) begin
              rvld_nxt  = 1'b0;
              state_nxt = S_OUTPUT;
            end
          end
        end
      end
      S_OUTPUT: begin
        res_nxt.engine_busy  = busy_r;
        res_nxt.queued_count = 4'(pend_r);
        ovalid_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      hcnt_r   <= '0;
      pend_r   <= '0;
      active_r <= '0;
      busy_r   <= 1'b0;
      pon_r    <= 1'b0;
      idx_r    <= '0;
      rvld_r   <= 1'b0;
      found_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      hcnt_r   <= hcnt_nxt;
      pend_r   <= pend_nxt;
      active_r <= active_nxt;
      busy_r   <= busy_nxt;
      pon_r    <= pon_nxt;
      idx_r    <= idx_nxt;
      rvld_r   <= rvld_nxt;
      found_r  <= found_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    res_r     <= res_nxt;
    rd_idx_r  <= rd_idx_nxt;
    best_r    <= best_nxt;
    bprio_r   <= bprio_nxt;
    bhandle_r <= bhandle_nxt;
  end

  // The pending count never exceeds the number of slots.
  `PDQ_ASSERT_IMPL(a_pend_range, clk, rst_n, 1'b1, pend_r <= CW'(pdq_pkg::SLOT_COUNT))
  // An idle engine has an empty queue whenever the sequencer is in S_IDLE.
  `PDQ_ASSERT_IMPL(a_idle_empty, clk, rst_n, !busy_r, pend_r == '0 || state_r != S_IDLE)
  // Accepting a beat never happens while a result is still held.
  `PDQ_ASSERT_NEXT(a_one_item, clk, rst_n, in_ch.valid && in_ch.ready, !ovalid_r)
endmodule
`default_nettype wire
